// ===== design/psg_register_dump_parser_macros.svh =====
// assertion macros shared by the parser modules
// expects signals named clock and reset in the scope of use
`ifndef PSG_REGISTER_DUMP_PARSER_MACROS_SVH
`define PSG_REGISTER_DUMP_PARSER_MACROS_SVH

// condition holds at every clock edge outside reset
`define PSG_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define PSG_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/psg_rdp_pkg.sv =====
// types and constants of the psg register dump parser
// no dependencies
package psg_rdp_pkg;

   localparam logic [3:0] SHORT_HEADER_LEN = 4'd3;
   localparam logic [3:0] LONG_HEADER_LAST = 4'd15;
   localparam logic [7:0] FORMAT_MARK      = 8'h1A;
   localparam logic [7:0] CMD_PAUSE        = 8'hFF;
   localparam logic [7:0] CMD_PAUSE_RUN    = 8'hFE;
   localparam logic [7:0] CMD_END          = 8'hFD;
   localparam logic [7:0] LAST_REGISTER    = 8'h0F;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_PAUSE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [5:0] {
      PH_HEADER      = 6'b000001,
      PH_LONG_HEADER = 6'b000010,
      PH_COMMAND     = 6'b000100,
      PH_VALUE       = 6'b001000,
      PH_PAUSE_COUNT = 6'b010000,
      PH_ENDED       = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       new_file;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] chip;
      logic [3:0] reg_index;
      logic [7:0] reg_value;
      logic [7:0] pause_count;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== design/psg_rdp_front.sv =====
// front end: accepts stream bytes, tracks header and command phase,
// builds result items for the queue; uses psg_rdp_pkg
`include "psg_register_dump_parser_macros.svh"
module psg_rdp_front import psg_rdp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  logic [1:0]       chip_select,
   input  queue_status_type q_status,
   output logic             push_valid,
   output rsp_type          push_data
);

   phase_type  phase_ff, phase_in, phase_cur, cmd_phase;
   logic [3:0] hdr_pos_ff, hdr_pos_in, hdr_pos_cur;
   logic [3:0] held_reg_ff, held_reg_in;
   logic       held_low_ff, held_low_in;
   logic       accept;
   logic       cmd_emit, emit;
   rsp_type    cmd_rsp, rsp;
   logic [7:0] b;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign b         = req_data.in_byte;

   assign phase_cur   = req_data.new_file ? PH_HEADER : phase_ff;
   assign hdr_pos_cur = req_data.new_file ? 4'd0 : hdr_pos_ff;

   // command byte decode
   always_comb begin
      cmd_phase   = PH_COMMAND;
      cmd_emit    = 1'b0;
      cmd_rsp     = '0;
      cmd_rsp.chip = chip_select;
      if (b == CMD_PAUSE) begin
         cmd_emit            = 1'b1;
         cmd_rsp.kind        = KIND_PAUSE;
         cmd_rsp.pause_count = 8'd1;
      end else if (b == CMD_PAUSE_RUN) begin
         cmd_phase = PH_PAUSE_COUNT;
      end else if (b == CMD_END) begin
         cmd_phase    = PH_ENDED;
         cmd_emit     = 1'b1;
         cmd_rsp.kind = KIND_END;
      end else begin
         cmd_phase = PH_VALUE;
      end
   end

   always_comb begin
      phase_in    = phase_cur;
      hdr_pos_in  = hdr_pos_cur;
      held_reg_in = held_reg_ff;
      held_low_in = held_low_ff;
      emit        = 1'b0;
      rsp         = '0;
      rsp.chip    = chip_select;
      case (phase_cur)
         PH_HEADER: begin
            if (hdr_pos_cur < SHORT_HEADER_LEN) begin
               hdr_pos_in = hdr_pos_cur + 4'd1;
            end else if (b == FORMAT_MARK) begin
               hdr_pos_in = hdr_pos_cur + 4'd1;
               phase_in   = PH_LONG_HEADER;
            end else begin
               phase_in    = cmd_phase;
               emit        = cmd_emit;
               rsp         = cmd_rsp;
               held_reg_in = b[3:0];
               held_low_in = (b <= LAST_REGISTER);
            end
         end
         PH_LONG_HEADER: begin
            if (hdr_pos_cur >= LONG_HEADER_LAST) begin
               phase_in = PH_COMMAND;
            end else begin
               hdr_pos_in = hdr_pos_cur + 4'd1;
            end
         end
         PH_COMMAND: begin
            phase_in    = cmd_phase;
            emit        = cmd_emit;
            rsp         = cmd_rsp;
            held_reg_in = b[3:0];
            held_low_in = (b <= LAST_REGISTER);
         end
         PH_VALUE: begin
            phase_in      = PH_COMMAND;
            emit          = held_low_ff;
            rsp.kind      = KIND_WRITE;
            rsp.reg_index = held_reg_ff;
            rsp.reg_value = b;
         end
         PH_PAUSE_COUNT: begin
            phase_in        = PH_COMMAND;
            emit            = (b != 8'd0);
            rsp.kind        = KIND_PAUSE;
            rsp.pause_count = b;
         end
         default: begin
            phase_in = PH_ENDED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_pos_ff  <= 4'd0;
         held_reg_ff <= 4'd0;
         held_low_ff <= 1'b1;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_pos_ff  <= hdr_pos_in;
         held_reg_ff <= held_reg_in;
         held_low_ff <= held_low_in;
      end
   end

   assign push_valid = accept && emit;
   assign push_data  = rsp;

   `PSG_ASSERT_IMPLY(ended_silent_a, (phase_ff == PH_ENDED) && accept && !req_data.new_file,
      !push_valid, "result pushed after end of track")

endmodule

// ===== design/psg_rdp_queue.sv =====
// short result queue between parser front and output stage
// uses psg_rdp_pkg
`include "psg_register_dump_parser_macros.svh"
module psg_rdp_queue import psg_rdp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  rsp_type          push_data,
   input  logic             pop,
   output rsp_type          head_data,
   output queue_status_type q_status
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data          = entry_ff[rd_ptr_ff];
   assign q_status.full      = (count_ff == CNT_FULL);
   assign q_status.not_empty = (count_ff != '0);

   `PSG_ASSERT_ALWAYS(push_full_a, !(push_valid && q_status.full), "push into full queue")
   `PSG_ASSERT_ALWAYS(count_range_a, count_ff <= CNT_FULL, "queue count above depth")
   `PSG_ASSERT_IMPLY(empty_ptr_a, count_ff == '0, wr_ptr_ff == rd_ptr_ff,
      "empty queue with unequal pointers")

endmodule

// ===== design/psg_rdp_back.sv =====
// output stage: moves queue head into the result register
// uses psg_rdp_pkg
`include "psg_register_dump_parser_macros.svh"
module psg_rdp_back import psg_rdp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  rsp_type          head_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign pop = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= head_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PSG_ASSERT_IMPLY(kind_code_a, rsp_valid_ff, rsp_data_ff.kind <= KIND_END,
      "result with undefined kind")

endmodule

// ===== design/psg_register_dump_parser.sv =====
// psg register dump parser, one stream byte per transfer
// the path from input transfer to the earliest result transfer runs through the queue, then the output register
// throughput: one byte per cycle while the result side keeps taking transfers
// req_stall rises only when the two-entry queue is full
// reset: synchronous; parser returns to header, chip select to 0, queue and output empty
module psg_register_dump_parser import psg_rdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   logic [1:0]       chip_select_ff;
   queue_status_type q_status;
   logic             push_valid;
   rsp_type          push_data;
   logic             pop;
   rsp_type          head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_select_ff <= 2'd0;
      end else if (csr_wr_en) begin
         chip_select_ff <= csr_wr_data;
      end
   end

   psg_rdp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .chip_select (chip_select_ff),
      .q_status    (q_status),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   psg_rdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .q_status   (q_status)
   );

   psg_rdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
